// File: design/dpr_pkg.sv
// Package for the diagonal phase rotator: fixed formats, word types,
// stage payload types and the CORDIC arctangent table. No dependencies.
package dpr_pkg;

  localparam int unsigned AMP_W      = 16;
  localparam int unsigned GUARD      = 32 - AMP_W;
  localparam int unsigned ZW         = 32;
  localparam int unsigned CW         = 35;
  localparam int unsigned GW         = 31;
  localparam int unsigned PW         = CW + GW;
  localparam int unsigned SPLIT      = (CW - 1) / 2;
  localparam int unsigned HW         = CW - SPLIT;
  localparam int unsigned SH         = 30 + GUARD;
  localparam int unsigned MAX_STAGES = 32;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [29:0] TURN_K    = 30'd683565276;
  localparam logic [29:0] GAIN_Q30  = 30'h26DD3B6A;

  localparam logic [ADDR_W-3:0] REG_EVOLUTION = '0;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_re;
    logic signed [AMP_W-1:0] amp_im;
    logic signed [15:0]      diag_value;
    logic                    is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] out_re;
    logic signed [AMP_W-1:0] out_im;
    logic                    out_last;
  } out_word_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_re;
    logic signed [AMP_W-1:0] amp_im;
    logic [ZW-1:0]           z;
    logic                    last;
  } ph_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 last;
  } cord_t;

  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [ZW-1:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// File: design/dpr_phase.sv
// Phase stages: evolution parameter times eigenvalue, then scaling to a
// 32-bit binary angle. Depends on dpr_pkg.
module dpr_phase (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic signed [15:0] evo_param_i,
  input  logic               ent_vld_i,
  input  dpr_pkg::in_word_t  ent_i,
  output logic               ph_vld_o,
  output dpr_pkg::ph_t       ph_o
);
  import dpr_pkg::*;

  logic               a_vld_q;
  in_word_t           a_word_q;
  logic signed [31:0] a_prod_q;
  logic signed [31:0] a_prod_d;

  logic               b_vld_q;
  ph_t                b_q;
  ph_t                b_d;

  logic signed [31:0] neg_prod;
  logic signed [30:0] turn_k_s;
  logic signed [62:0] turn_prod;

  assign a_prod_d = 32'(evo_param_i) * 32'(ent_i.diag_value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= ent_vld_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_word_q <= ent_i;
      a_prod_q <= a_prod_d;
      b_q      <= b_d;
    end
  end

  always_comb begin
    neg_prod  = -a_prod_q;
    turn_k_s  = {1'b0, TURN_K};
    turn_prod = 63'(neg_prod) * 63'(turn_k_s);
    b_d.amp_re = a_word_q.amp_re;
    b_d.amp_im = a_word_q.amp_im;
    b_d.z      = turn_prod[52:21];
    b_d.last   = a_word_q.is_last;
  end

  assign ph_vld_o = b_vld_q;
  assign ph_o     = b_q;

endmodule

// File: design/dpr_cordic.sv
// Half-plane fold and unrolled CORDIC rotation, one register per
// micro-rotation. Depends on dpr_pkg.
module dpr_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          ph_vld_i,
  input  dpr_pkg::ph_t  ph_i,
  output logic          cord_vld_o,
  output dpr_pkg::cord_t cord_o
);
  import dpr_pkg::*;

  logic [STAGES:0] vld_q;
  cord_t           st_q [STAGES+1];
  cord_t           st_d [STAGES+1];

  logic signed [CW-1:0] x_ext;
  logic signed [CW-1:0] y_ext;

  always_comb begin
    x_ext = {{(CW-AMP_W){ph_i.amp_re[AMP_W-1]}}, ph_i.amp_re} <<< GUARD;
    y_ext = {{(CW-AMP_W){ph_i.amp_im[AMP_W-1]}}, ph_i.amp_im} <<< GUARD;
    st_d[0].last = ph_i.last;
    if (ph_i.z[ZW-1] != ph_i.z[ZW-2]) begin
      st_d[0].x = -x_ext;
      st_d[0].y = -y_ext;
      st_d[0].z = {~ph_i.z[ZW-1], ph_i.z[ZW-2:0]};
    end else begin
      st_d[0].x = x_ext;
      st_d[0].y = y_ext;
      st_d[0].z = ph_i.z;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [ZW-1:0]        at;
    always_comb begin
      xs = st_q[g].x;
      ys = st_q[g].y;
      dx = ys >>> g;
      dy = xs >>> g;
      at = atan_turn(5'(g));
      st_d[g+1].last = st_q[g].last;
      if (!st_q[g].z[ZW-1]) begin
        st_d[g+1].x = xs - dx;
        st_d[g+1].y = ys + dy;
        st_d[g+1].z = st_q[g].z - at;
      end else begin
        st_d[g+1].x = xs + dx;
        st_d[g+1].y = ys - dy;
        st_d[g+1].z = st_q[g].z + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-1:0], ph_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= STAGES; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign cord_vld_o = vld_q[STAGES];
  assign cord_o     = st_q[STAGES];

`ifndef SYNTHESIS
  a_fold_residual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (st_q[0].z[ZW-1] == st_q[0].z[ZW-2]))
    else $error("folded angle outside the right half-plane");
`endif

endmodule

// File: design/dpr_gain.sv
// Gain compensation in two stages (split partial products, then sum,
// round and saturate) ending in the output register. Depends on dpr_pkg.
module dpr_gain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              cord_vld_i,
  input  dpr_pkg::cord_t    cord_i,
  output logic              out_vld_o,
  output dpr_pkg::out_word_t out_word_o
);
  import dpr_pkg::*;

  localparam int unsigned PPW = HW + GW;
  localparam logic signed [PW-1:0] RND = PW'(66'd1 << (SH - 1));
  localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (AMP_W - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

  logic signed [GW-1:0] gain_s;

  logic                  g_vld_q;
  logic                  g_last_q;
  logic signed [PPW-1:0] xh_q, xl_q, yh_q, yl_q;
  logic signed [PPW-1:0] xh_d, xl_d, yh_d, yl_d;

  logic      out_vld_q;
  out_word_t out_q;
  out_word_t out_d;

  function automatic logic signed [AMP_W-1:0] finish(
    input logic signed [PPW-1:0] ph,
    input logic signed [PPW-1:0] pl
  );
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] r;
    logic signed [AMP_W-1:0] res;
    sum = (PW'(ph) <<< SPLIT) + PW'(pl) + RND;
    r   = sum >>> SH;
    if (r > SAT_HI) begin
      res = SAT_HI[AMP_W-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[AMP_W-1:0];
    end else begin
      res = r[AMP_W-1:0];
    end
    return res;
  endfunction

  always_comb begin
    logic signed [HW-1:0] xh, xl, yh, yl;
    gain_s = {1'b0, GAIN_Q30};
    xh = cord_i.x[CW-1:SPLIT];
    yh = cord_i.y[CW-1:SPLIT];
    xl = HW'({1'b0, cord_i.x[SPLIT-1:0]});
    yl = HW'({1'b0, cord_i.y[SPLIT-1:0]});
    xh_d = PPW'(xh) * PPW'(gain_s);
    xl_d = PPW'(xl) * PPW'(gain_s);
    yh_d = PPW'(yh) * PPW'(gain_s);
    yl_d = PPW'(yl) * PPW'(gain_s);
  end

  always_comb begin
    out_d.out_re   = finish(xh_q, xl_q);
    out_d.out_im   = finish(yh_q, yl_q);
    out_d.out_last = g_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      g_vld_q   <= cord_vld_i;
      out_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g_last_q <= cord_i.last;
      xh_q     <= xh_d;
      xl_q     <= xl_d;
      yh_q     <= yh_d;
      yl_q     <= yl_d;
      out_q    <= out_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_word_o = out_q;

endmodule

// File: design/diagonal_phase_rotator_unit.sv
// Diagonal phase rotator top level: input skid word, configuration port and
// the phase, CORDIC and gain pipeline. Depends on dpr_pkg and the dpr_ modules.
//
// Takes one word per clock, at full rate while in_ready_o is high, and returns
// one rotated word per word taken, in order. Each word is rotated by
// -(evolution_param/2)*diag_value radians through a pipelined CORDIC of
// CORDIC_STAGES micro-rotations (at most 32), gain-compensated, rounded half up
// and saturated to Q1.15. The pipeline has CORDIC_STAGES + 5 register stages:
// two for the phase product and scaling, one for the half-plane fold, one per
// micro-rotation and two for gain and the output register. When the output is
// stalled the whole pipeline holds and one further word is taken into a skid
// register. Write evolution_param only while no word is in flight.
module diagonal_phase_rotator_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  dpr_pkg::in_word_t          in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output dpr_pkg::out_word_t         out_word_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dpr_pkg::*;

  localparam int unsigned NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic               en;
  logic signed [15:0] evo_q;
  logic               cfg_wr;

  logic     skid_vld_q, skid_vld_d;
  in_word_t skid_q;
  logic     ent_vld;
  in_word_t ent_word;

  logic  ph_vld;
  ph_t   ph;
  logic  cord_vld;
  cord_t cord;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_EVOLUTION);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evo_q <= '0;
    end else if (cfg_wr) begin
      evo_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_EVOLUTION) begin
      prdata = {16'b0, evo_q};
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = !skid_vld_q;
  assign ent_vld    = skid_vld_q || in_valid_i;
  assign ent_word   = skid_vld_q ? skid_q : in_word_i;

  always_comb begin
    skid_vld_d = skid_vld_q;
    if (en) begin
      skid_vld_d = 1'b0;
    end else if (in_valid_i && !skid_vld_q) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && !skid_vld_q) begin
      skid_q <= in_word_i;
    end
  end

  dpr_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .evo_param_i (evo_q),
    .ent_vld_i   (ent_vld),
    .ent_i       (ent_word),
    .ph_vld_o    (ph_vld),
    .ph_o        (ph)
  );

  dpr_cordic #(
    .STAGES (NS)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ph_vld_i   (ph_vld),
    .ph_i       (ph),
    .cord_vld_o (cord_vld),
    .cord_o     (cord)
  );

  dpr_gain u_gain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cord_vld_i (cord_vld),
    .cord_i     (cord),
    .out_vld_o  (out_valid_o),
    .out_word_o (out_word_o)
  );

`ifndef SYNTHESIS
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(!en && in_valid_i))
    else $error("skid word loaded while the pipeline advanced");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && en |=> !skid_vld_q)
    else $error("skid word not drained on advance");
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !en |=> skid_vld_q && $stable(skid_q))
    else $error("skid word lost during stall");
`endif

endmodule
